### hdl/y86ex_pkg.sv
// ---------------------------------------------------------------------------
// y86ex_pkg
// Encodings, word layouts and helper functions for the Y86-64 execute stage.
// ---------------------------------------------------------------------------
package y86ex_pkg;

    localparam int WORD_W = 64;

    // Instruction codes
    localparam logic [3:0] ICODE_NOP    = 4'd1;
    localparam logic [3:0] ICODE_RRMOV  = 4'd2;
    localparam logic [3:0] ICODE_IRMOV  = 4'd3;
    localparam logic [3:0] ICODE_RMMOV  = 4'd4;
    localparam logic [3:0] ICODE_MRMOV  = 4'd5;
    localparam logic [3:0] ICODE_OP     = 4'd6;
    localparam logic [3:0] ICODE_JXX    = 4'd7;
    localparam logic [3:0] ICODE_CALL   = 4'd8;
    localparam logic [3:0] ICODE_RET    = 4'd9;
    localparam logic [3:0] ICODE_PUSH   = 4'd10;
    localparam logic [3:0] ICODE_POP    = 4'd11;

    // ALU functions
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_AND = 4'd2;

    // Jump / move conditions
    localparam logic [3:0] COND_ALWAYS = 4'd0;
    localparam logic [3:0] COND_LE     = 4'd1;
    localparam logic [3:0] COND_L      = 4'd2;
    localparam logic [3:0] COND_E      = 4'd3;
    localparam logic [3:0] COND_NE     = 4'd4;
    localparam logic [3:0] COND_GE     = 4'd5;
    localparam logic [3:0] COND_G      = 4'd6;

    localparam logic [1:0] STAT_AOK  = 2'd0;
    localparam logic [3:0] REG_NONE  = 4'd15;

    localparam logic [WORD_W-1:0] STACK_STEP = 64'd8;
    localparam logic [WORD_W-1:0] STACK_DEC  = 64'hFFFF_FFFF_FFFF_FFF8;
    localparam int                SIGN_BIT   = 63;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 216;

    // Condition codes
    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } cc_t;

    localparam cc_t CC_RESET = '{zf: 1'b1, sf: 1'b0, of: 1'b0};

    // Input word, last field first (first field in the lowest bits)
    typedef struct packed {
        logic [1:0]        wb_stage_status;
        logic [1:0]        mem_stage_status;
        logic [3:0]        dest_m_in;
        logic [3:0]        dest_e_in;
        logic [WORD_W-1:0] operand_b;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] const_value;
        logic [3:0]        instr_fun;
        logic [3:0]        instr_code;
        logic [1:0]        instr_status;
    } exe_in_t;

    // Result word
    typedef struct packed {
        logic [WORD_W-1:0] fwd_value;
        logic [3:0]        fwd_dest;
        logic              insert_bubble;
        logic [3:0]        dest_m_out;
        logic [3:0]        dest_e_out;
        logic [WORD_W-1:0] pass_value_a;
        logic [WORD_W-1:0] exec_value;
        logic              cond_flag;
        logic [3:0]        out_code;
        logic [1:0]        out_status;
    } exe_out_t;

    // Evaluate a jump / conditional-move condition against the codes
    function automatic logic eval_cond(input logic [3:0] code, input logic [3:0] fun,
                                       input cc_t cc);
        logic lt;
        logic res;
        lt  = cc.sf ^ cc.of;
        res = 1'b0;
        if (code == ICODE_JXX || code == ICODE_RRMOV) begin
            unique case (fun)
                COND_ALWAYS: res = 1'b1;
                COND_LE:     res = lt | cc.zf;
                COND_L:      res = lt;
                COND_E:      res = cc.zf;
                COND_NE:     res = ~cc.zf;
                COND_GE:     res = ~lt;
                COND_G:      res = ~lt & ~cc.zf;
                default:     res = 1'b0;
            endcase
        end
        return res;
    endfunction

endpackage

### hdl/y86_execute_stage.sv
// ---------------------------------------------------------------------------
// y86_execute_stage
// Y86-64 pipeline execute stage: ALU, condition codes, jump/cmov condition
// and bubble control for the memory-stage register.
// ---------------------------------------------------------------------------
// Usage:
//   s_tdata carries one instruction word from the execute register together
//   with the memory and writeback stage status; m_tdata carries the word
//   loaded into the memory-stage register plus the unbubbled forwarding pair.
//   Each accepted input word gives exactly one output word, in order.
// Pipeline and throughput:
//   A word is held in the input register, evaluated by the ALU and
//   condition logic, then captured in the output register when that
//   register is free; m_tvalid rises as it is captured. One word per cycle
//   is sustained while m_tready stays high; the only feedback is the
//   three-bit condition-code register, which updates as the word moves into
//   the output register.
// Reset:
//   aresetn low empties both registers and sets ZF=1, SF=0, OF=0.
// Back-pressure:
//   While m_tready is low the output word holds; one further word may wait
//   in the input register, after which s_tready drops. Nothing is lost.
// ---------------------------------------------------------------------------
module y86_execute_stage
    import y86ex_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // instr_status, instr_code, instr_fun, const_value, operand_a, operand_b,
    // dest_e_in, dest_m_in, mem_stage_status, wb_stage_status (low bit up)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // out_status, out_code, cond_flag, exec_value, pass_value_a, dest_e_out,
    // dest_m_out, insert_bubble, fwd_dest, fwd_value (low bit up)
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int IN_USED  = $bits(exe_in_t);
    localparam int OUT_USED = $bits(exe_out_t);

    exe_in_t  in_reg;
    logic     in_valid_reg;
    exe_out_t out_reg, out_next;
    logic     out_valid_reg;
    cc_t      cc_reg, cc_next;

    logic              out_load;
    logic              in_adv;
    logic              fault;
    logic              cc_update;
    logic              cnd;
    logic [3:0]        alu_fun;
    logic [3:0]        dst_e;
    logic [WORD_W-1:0] alu_a, alu_b, alu_r;

    // Handshake: output register frees when empty or taken
    assign out_load = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_USED){1'b0}}, out_reg};

    // Select ALU operand A
    always_comb begin
        unique case (in_reg.instr_code)
            ICODE_RRMOV, ICODE_OP:                  alu_a = in_reg.operand_a;
            ICODE_IRMOV, ICODE_RMMOV, ICODE_MRMOV:  alu_a = in_reg.const_value;
            ICODE_CALL, ICODE_PUSH:                 alu_a = STACK_DEC;
            ICODE_RET, ICODE_POP:                   alu_a = STACK_STEP;
            default:                                alu_a = '0;
        endcase
    end

    // Select ALU operand B and function
    always_comb begin
        unique case (in_reg.instr_code)
            ICODE_RMMOV, ICODE_MRMOV, ICODE_OP, ICODE_CALL,
            ICODE_RET, ICODE_PUSH, ICODE_POP:       alu_b = in_reg.operand_b;
            default:                                alu_b = '0;
        endcase
        alu_fun = (in_reg.instr_code == ICODE_OP) ? in_reg.instr_fun : ALU_ADD;
    end

    // ALU; functions above and behave as xor
    always_comb begin
        unique case (alu_fun)
            ALU_ADD: alu_r = alu_a + alu_b;
            ALU_SUB: alu_r = alu_b - alu_a;
            ALU_AND: alu_r = alu_a & alu_b;
            default: alu_r = alu_a ^ alu_b;
        endcase
    end

    // Condition codes: update for OPq unless a later stage has faulted
    assign fault     = (in_reg.mem_stage_status != STAT_AOK) ||
                       (in_reg.wb_stage_status != STAT_AOK);
    assign cc_update = in_adv && (in_reg.instr_code == ICODE_OP) && !fault;

    always_comb begin
        cc_next    = cc_reg;
        cc_next.zf = (alu_r == '0);
        cc_next.sf = alu_r[SIGN_BIT];
        unique case (alu_fun)
            ALU_ADD: cc_next.of = (alu_a[SIGN_BIT] == alu_b[SIGN_BIT]) &&
                                  (alu_r[SIGN_BIT] != alu_a[SIGN_BIT]);
            ALU_SUB: cc_next.of = (alu_a[SIGN_BIT] != alu_b[SIGN_BIT]) &&
                                  (alu_r[SIGN_BIT] != alu_b[SIGN_BIT]);
            default: cc_next.of = 1'b0;
        endcase
    end

    // Condition and cmov cancel; OPq never tests, so old codes suffice
    assign cnd   = eval_cond(in_reg.instr_code, in_reg.instr_fun, cc_reg);
    assign dst_e = (in_reg.instr_code == ICODE_RRMOV && !cnd) ? REG_NONE
                                                              : in_reg.dest_e_in;

    // Build the result word, bubbling on a later-stage fault
    always_comb begin
        out_next.fwd_dest  = dst_e;
        out_next.fwd_value = alu_r;
        if (fault) begin
            out_next.out_status    = STAT_AOK;
            out_next.out_code      = ICODE_NOP;
            out_next.cond_flag     = 1'b0;
            out_next.exec_value    = '0;
            out_next.pass_value_a  = '0;
            out_next.dest_e_out    = REG_NONE;
            out_next.dest_m_out    = REG_NONE;
            out_next.insert_bubble = 1'b1;
        end else begin
            out_next.out_status    = in_reg.instr_status;
            out_next.out_code      = in_reg.instr_code;
            out_next.cond_flag     = cnd;
            out_next.exec_value    = alu_r;
            out_next.pass_value_a  = in_reg.operand_a;
            out_next.dest_e_out    = dst_e;
            out_next.dest_m_out    = in_reg.dest_m_in;
            out_next.insert_bubble = 1'b0;
        end
    end

    // Control state and condition codes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cc_reg        <= CC_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cc_update) begin
                cc_reg <= cc_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= exe_in_t'(s_tdata[IN_USED-1:0]);
        end
        if (in_adv) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // Codes only move when an OPq word advances without a fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(cc_reg) |-> $past(cc_update))
        else $error("condition codes changed without an OPq update");

    // Codes come out of reset as ZF set, SF and OF clear
    assert property (@(posedge aclk)
        !aresetn |=> (cc_reg == CC_RESET))
        else $error("condition codes not at reset value");

    // A bubble carries a NOP with no destinations
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.insert_bubble) |->
            (out_reg.out_code == ICODE_NOP && out_reg.dest_e_out == REG_NONE &&
             out_reg.dest_m_out == REG_NONE && !out_reg.cond_flag))
        else $error("bubble word not a clean NOP");

    // A cmov that does not move has its destination cancelled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.out_code == ICODE_RRMOV && !out_reg.cond_flag) |->
            (out_reg.fwd_dest == REG_NONE))
        else $error("untaken cmov kept its destination");

    // A word held in the input register is not overwritten while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(in_reg)))
        else $error("stalled input word lost");
`endif

endmodule
